// ===== rtl/hqo_pkg.sv =====
// Shared types and constants for the hall quadrature odometer speed core.
// Holds the sequencer state type, field widths and the hall step decode table.
// No dependencies.
package hqo_pkg;

  localparam int unsigned TIMER_W = 16;
  localparam int unsigned HALL_W  = 2;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned DIR_W   = 2;

  localparam logic [TIMER_W-1:0] LIMIT_RESET = 16'd1562;

  // Scaling by 2^24 followed by a division by 256 equals one scale of 2^16.
  localparam int unsigned SPEED_FRAC_W = 16;

  localparam logic CMD_EDGE  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic signed [SPEED_W-1:0] SPEED_MAX = 16'sh7fff;
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } hqo_state_e;

  // Indexed by {new hall, previous hall}; -1, 0 or +1 as a 2-bit signed value.
  localparam logic signed [DIR_W-1:0] STEP_TABLE [16] = '{
    2'b00, 2'b11, 2'b01, 2'b00,
    2'b01, 2'b00, 2'b00, 2'b11,
    2'b11, 2'b00, 2'b00, 2'b01,
    2'b00, 2'b01, 2'b11, 2'b00
  };

endpackage

// ===== rtl/hqo_div.sv =====
// Bit-serial restoring divider for the speed estimate, one quotient bit a cycle.
// Unsigned numerator and denominator; depends on nothing outside this file.
module hqo_div #(
  parameter int unsigned NUM_W = 19,
  parameter int unsigned DEN_W = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;

  // The numerator register shifts out dividend bits at the top while the
  // quotient bits enter at the bottom.
  assign shifted = {rem_q, num_q[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (diff[DEN_W]) begin
        rem_d = shifted[DEN_W-1:0];
        num_d = {num_q[NUM_W-2:0], 1'b0};
      end else begin
        rem_d = diff[DEN_W-1:0];
        num_d = {num_q[NUM_W-2:0], 1'b1};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

// ===== rtl/hall_quadrature_odometer_speed_core.sv =====
// Hall quadrature odometer: position count and averaged speed from hall edges.
// An edge word is accepted in ST_IDLE and reaches the output register from ST_FINISH,
// which waits while the output is held. A query word that needs the divider first
// passes ST_DIVIDE, where the bit-serial divider produces one quotient bit per cycle;
// other queries go straight to ST_FINISH. One word is in flight at a time. Reset
// clears the position, the interval ring and its running sums, and loads limit 1562.
module hall_quadrature_odometer_speed_core
  import hqo_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [TIMER_W-1:0]  cfg_data_i,      // standstill_limit
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,    // timer_now[15:0], hall_bits[17:16], zero pad
  input  logic                s_axis_tuser,    // cmd
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [55:0]         m_axis_tdata     // position_count[31:0], speed[47:32],
                                               // standstill[48], step_direction[50:49], pad
);

  localparam int unsigned PTR_W     = $clog2(RING_DEPTH);
  localparam int unsigned DT_W      = TIMER_W + $clog2(RING_DEPTH);
  localparam int unsigned DS_W      = $clog2(RING_DEPTH + 1) + 1;
  localparam int unsigned DS_MAG_W  = DS_W - 1;
  localparam int unsigned NUM_W     = DS_MAG_W + SPEED_FRAC_W;

  hqo_state_e state_q, state_d;

  logic [TIMER_W-1:0]        limit_q;
  logic [HALL_W-1:0]         prev_hall_q;
  logic [TIMER_W-1:0]        prev_time_q;
  logic                      stopped_q;
  logic [POS_W-1:0]          step_count_q;
  logic [TIMER_W-1:0]        ivl_ring_q [RING_DEPTH];
  logic signed [DIR_W-1:0]   dir_ring_q [RING_DEPTH];
  logic [PTR_W-1:0]          ptr_q;
  logic [DT_W-1:0]           dt_sum_q;
  logic signed [DS_W-1:0]    ds_sum_q;

  logic signed [SPEED_W-1:0] res_speed_q;
  logic signed [DIR_W-1:0]   res_dir_q;
  logic                      neg_q;
  logic                      m_valid_q;
  logic [55:0]               m_data_q;

  logic                      in_fire;
  logic                      is_query;
  logic [TIMER_W-1:0]        timer_now;
  logic [HALL_W-1:0]         hall_bits;
  logic signed [DIR_W-1:0]   dir;
  logic [PTR_W-1:0]          ptr_nxt;
  logic [TIMER_W-1:0]        interval;
  logic [TIMER_W-1:0]        old_ivl;
  logic signed [DIR_W-1:0]   old_dir;
  logic                      stopped_nxt;
  logic                      need_div;
  logic [DS_W-1:0]           ds_abs;
  logic                      div_start;
  logic                      div_done;
  logic [NUM_W-1:0]          div_quo;
  logic signed [SPEED_W-1:0] sat_speed;
  logic                      out_free;
  logic                      load_out;

  assign timer_now = s_axis_tdata[TIMER_W-1:0];
  assign hall_bits = s_axis_tdata[TIMER_W +: HALL_W];
  assign is_query  = (s_axis_tuser == CMD_QUERY);
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  assign dir      = STEP_TABLE[{hall_bits, prev_hall_q}];
  assign ptr_nxt  = (ptr_q == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
  assign interval = timer_now - prev_time_q;
  assign old_ivl  = ivl_ring_q[ptr_nxt];
  assign old_dir  = dir_ring_q[ptr_nxt];

  // Standstill is checked against the elapsed time before any speed is formed.
  assign stopped_nxt = stopped_q || (interval > limit_q);
  assign need_div    = !stopped_nxt && (dt_sum_q != '0) && (ds_sum_q != '0);
  assign ds_abs      = ds_sum_q[DS_W-1] ? -ds_sum_q : ds_sum_q;
  assign div_start   = in_fire && is_query && need_div;

  hqo_div #(
    .NUM_W (NUM_W),
    .DEN_W (DT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({ds_abs[DS_MAG_W-1:0], {SPEED_FRAC_W{1'b0}}}),
    .den_i   (dt_sum_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // The quotient is a magnitude; a negative result may reach one step further.
  always_comb begin
    if (!neg_q) begin
      if (div_quo > NUM_W'(SPEED_MAX)) begin
        sat_speed = SPEED_MAX;
      end else begin
        sat_speed = div_quo[SPEED_W-1:0];
      end
    end else begin
      if (div_quo > NUM_W'(17'd32768)) begin
        sat_speed = SPEED_MIN;
      end else begin
        sat_speed = -div_quo[SPEED_W-1:0];
      end
    end
  end

  assign out_free = !m_valid_q || m_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = div_start ? ST_DIVIDE : ST_FINISH;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    unique case (state_q)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_DIVIDE: s_axis_tready = 1'b0;
      ST_FINISH: load_out      = out_free;
      default:   s_axis_tready = 1'b0;
    endcase
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      limit_q      <= LIMIT_RESET;
      prev_hall_q  <= '0;
      prev_time_q  <= '0;
      stopped_q    <= 1'b0;
      step_count_q <= '0;
      ptr_q        <= '0;
      dt_sum_q     <= '0;
      ds_sum_q     <= '0;
      m_valid_q    <= 1'b0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        ivl_ring_q[i] <= '0;
        dir_ring_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (in_fire) begin
        if (is_query) begin
          stopped_q <= stopped_nxt;
        end else begin
          stopped_q           <= 1'b0;
          prev_hall_q         <= hall_bits;
          prev_time_q         <= timer_now;
          step_count_q        <= step_count_q + {{(POS_W-DIR_W){dir[DIR_W-1]}}, dir};
          ptr_q               <= ptr_nxt;
          ivl_ring_q[ptr_nxt] <= interval;
          dir_ring_q[ptr_nxt] <= dir;
          // Running sums follow the ring: drop the overwritten entry, add the new one.
          dt_sum_q <= dt_sum_q - DT_W'(old_ivl) + DT_W'(interval);
          ds_sum_q <= ds_sum_q - {{(DS_W-DIR_W){old_dir[DIR_W-1]}}, old_dir}
                               + {{(DS_W-DIR_W){dir[DIR_W-1]}}, dir};
        end
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      neg_q       <= ds_sum_q[DS_W-1];
      res_speed_q <= '0;
      res_dir_q   <= is_query ? '0 : dir;
    end else if (div_done) begin
      res_speed_q <= sat_speed;
    end
    if (load_out) begin
      m_data_q <= {5'b0, res_dir_q, stopped_q, res_speed_q, step_count_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== dv/hall_quadrature_odometer_speed_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for hall_quadrature_odometer_speed_core: a directed table, then
// random hall sequences and speed queries under several standstill limits and idle patterns.
// Depends on hqo_pkg and the core RTL only.
module hall_quadrature_odometer_speed_core_tb;
  import hqo_pkg::*;

  localparam int RESET_CYCLES = 10;
  localparam int LONG_HOLD    = 400;
  localparam int REPORT_LIMIT = 10;
  localparam int DRAIN_CYCLES = 40;
  localparam int SETTLE       = 4;
  localparam int RING         = 4;
  localparam logic [TIMER_W-1:0] RESET_LIMIT = 16'd1562;

  // Step per transition, indexed by {new hall, previous hall}.
  localparam int HALL_STEP [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
  // Valid quadrature order of the two sensors.
  localparam logic [HALL_W-1:0] GRAY [4] = '{2'd0, 2'd1, 2'd3, 2'd2};

  typedef struct packed {
    logic signed [POS_W-1:0]   position;
    logic signed [SPEED_W-1:0] speed;
    logic                      standstill;
    logic signed [DIR_W-1:0]   direction;
  } odo_word_t;

  typedef struct packed {
    logic               cmd;
    logic [TIMER_W-1:0] timer;
    logic [HALL_W-1:0]  hall;
    logic               typed;
    odo_word_t          want;
  } stim_row_t;

  localparam odo_word_t NO_WANT = '0;

  // Rows with typed set carry their own expected word; the rest use the predictor.
  localparam stim_row_t DIRECTED_ROWS [25] = '{
    '{CMD_QUERY, 16'd0,     2'd3, 1'b1, '{32'sd0,  16'sd0,    1'b0, 2'sd0}},
    '{CMD_EDGE,  16'd1,     2'd1, 1'b1, '{32'sd1,  16'sd0,    1'b0, 2'sd1}},
    '{CMD_QUERY, 16'd1,     2'd2, 1'b1, '{32'sd1,  SPEED_MAX, 1'b0, 2'sd0}},
    '{CMD_EDGE,  16'd2,     2'd0, 1'b0, NO_WANT},
    '{CMD_EDGE,  16'd3,     2'd2, 1'b0, NO_WANT},
    '{CMD_EDGE,  16'd3,     2'd3, 1'b0, NO_WANT},
    '{CMD_QUERY, 16'd3,     2'd1, 1'b1, '{-32'sd2, SPEED_MIN, 1'b0, 2'sd0}},
    '{CMD_QUERY, 16'd1565,  2'd0, 1'b0, NO_WANT},
    '{CMD_QUERY, 16'd1566,  2'd0, 1'b1, '{-32'sd2, 16'sd0,    1'b1, 2'sd0}},
    '{CMD_QUERY, 16'd3,     2'd0, 1'b1, '{-32'sd2, 16'sd0,    1'b1, 2'sd0}},
    '{CMD_EDGE,  16'hffff,  2'd1, 1'b0, NO_WANT},
    '{CMD_EDGE,  16'd4,     2'd3, 1'b0, NO_WANT},
    '{CMD_QUERY, 16'hffff,  2'd3, 1'b0, NO_WANT},
    '{CMD_EDGE,  16'd10,    2'd3, 1'b0, NO_WANT},
    '{CMD_EDGE,  16'd20,    2'd2, 1'b0, NO_WANT},
    '{CMD_EDGE,  16'd30,    2'd0, 1'b0, NO_WANT},
    '{CMD_EDGE,  16'd40,    2'd1, 1'b0, NO_WANT},
    '{CMD_QUERY, 16'd40,    2'd0, 1'b0, NO_WANT},
    '{CMD_EDGE,  16'd40,    2'd3, 1'b0, NO_WANT},
    '{CMD_EDGE,  16'd40,    2'd2, 1'b0, NO_WANT},
    '{CMD_EDGE,  16'd40,    2'd0, 1'b0, NO_WANT},
    '{CMD_EDGE,  16'd40,    2'd1, 1'b0, NO_WANT},
    '{CMD_QUERY, 16'd40,    2'd2, 1'b0, NO_WANT},
    '{CMD_EDGE,  16'hffff,  2'd0, 1'b0, NO_WANT},
    '{CMD_QUERY, 16'hffff,  2'd1, 1'b0, NO_WANT}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [TIMER_W-1:0] cfg_data_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [23:0]        s_axis_tdata;
  logic               s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [55:0]        m_axis_tdata;

  // Predictor state.
  logic [TIMER_W-1:0] odo_limit;
  logic [TIMER_W-1:0] odo_prev_time;
  logic [HALL_W-1:0]  odo_prev_hall;
  logic               odo_stopped;
  logic [POS_W-1:0]   odo_position;
  logic [TIMER_W-1:0] odo_interval [RING];
  int                 odo_dir [RING];
  int                 odo_ptr;

  odo_word_t pending_odometry [$];

  int  tx_idle;
  int  rx_idle;
  bit  stall_req;
  int  fail_count;
  int  words_sent;
  int  queries_sent;
  int  words_seen;
  logic [TIMER_W-1:0] tb_timer;
  int  gray_idx;
  int  motion;

  hall_quadrature_odometer_speed_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("hall_quadrature_odometer_speed_core test failed");
    $finish;
  end

  function automatic odo_word_t predict_odometry(logic cmd, logic [TIMER_W-1:0] now,
                                                 logic [HALL_W-1:0] hall);
    odo_word_t          w;
    int                 dir_step;
    int                 i;
    logic [TIMER_W-1:0] elapsed;
    longint             dt_sum;
    longint             ds_sum;
    longint             ratio;
    w = '0;
    if (cmd == CMD_EDGE) begin
      dir_step = HALL_STEP[{hall, odo_prev_hall}];
      odo_position = odo_position + dir_step;
      // The ring pointer moves before the entry is written.
      odo_ptr = (odo_ptr + 1) % RING;
      odo_interval[odo_ptr] = now - odo_prev_time;
      odo_dir[odo_ptr] = dir_step;
      odo_stopped = 1'b0;
      odo_prev_hall = hall;
      odo_prev_time = now;
      w.direction = dir_step[DIR_W-1:0];
    end else begin
      elapsed = now - odo_prev_time;
      if (elapsed > odo_limit) odo_stopped = 1'b1;
      if (!odo_stopped) begin
        dt_sum = 0;
        ds_sum = 0;
        for (i = 0; i < RING; i++) begin
          dt_sum += longint'(odo_interval[i]);
          ds_sum += longint'(odo_dir[i]);
        end
        if (dt_sum != 0) begin
          ratio = (ds_sum * longint'(16777216)) / dt_sum;
          ratio = ratio / longint'(256);
          if (ratio > 32767) ratio = 32767;
          if (ratio < -32768) ratio = -32768;
          w.speed = ratio[SPEED_W-1:0];
        end
      end
    end
    w.position = odo_position;
    w.standstill = odo_stopped;
    return w;
  endfunction

  task automatic offer_word(logic cmd, logic [TIMER_W-1:0] now, logic [HALL_W-1:0] hall,
                            logic typed, odo_word_t want);
    odo_word_t predicted;
    if ($urandom_range(0, 99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, hall, now};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_odometry(cmd, now, hall);
    pending_odometry.push_back(typed ? want : predicted);
    words_sent++;
    if (cmd == CMD_QUERY) queries_sent++;
  endtask

  task automatic write_limit(logic [TIMER_W-1:0] value);
    while (pending_odometry.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    odo_limit = value;
  endtask

  // Mostly clean quadrature motion with occasional reversals, some out-of-order hall
  // words, and queries with random hall bits. The timer mostly advances by small steps.
  task automatic run_phase(int count, int snd_idle, int rcv_idle);
    int                 kind;
    int                 sel;
    logic [TIMER_W-1:0] adv;
    logic [HALL_W-1:0]  hall;
    logic               cmd;
    tx_idle = snd_idle;
    rx_idle = rcv_idle;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) adv = '0;
      else if (sel < 85) adv = TIMER_W'($urandom_range(1, 300));
      else if (sel < 95) adv = TIMER_W'($urandom_range(300, 3000));
      else adv = TIMER_W'($urandom_range(0, 65535));
      tb_timer = tb_timer + adv;
      kind = $urandom_range(0, 99);
      hall = HALL_W'($urandom_range(0, 3));
      if (kind < 60) begin
        cmd = CMD_EDGE;
        if ($urandom_range(0, 15) == 0) motion = -motion;
        gray_idx = (gray_idx + motion) & 3;
        hall = GRAY[gray_idx];
      end else if (kind < 70) begin
        cmd = CMD_EDGE;
        gray_idx = {hall[1], hall[1] ^ hall[0]};
      end else begin
        cmd = CMD_QUERY;
      end
      offer_word(cmd, tb_timer, hall, 1'b0, NO_WANT);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic check_word(logic [55:0] data);
    odo_word_t got;
    odo_word_t want;
    got.position   = data[31:0];
    got.speed      = data[47:32];
    got.standstill = data[48];
    got.direction  = data[50:49];
    words_seen++;
    if (pending_odometry.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("Unexpected output word %h.", data);
    end else begin
      want = pending_odometry.pop_front();
      if (got.position !== want.position || got.speed !== want.speed ||
          got.standstill !== want.standstill || got.direction !== want.direction) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("Mismatch on output word %0d: position %0d/%0d speed %0d/%0d",
                   words_seen, want.position, got.position, want.speed, got.speed);
          $display("  standstill %0b/%0b direction %0d/%0d (expected/actual)",
                   want.standstill, got.standstill, want.direction, got.direction);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_word(m_axis_tdata);
  end

  // Output side: random back-pressure, plus one long hold when requested.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        stall_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_EDGE;
    stall_req     = 1'b0;
    tx_idle       = 31;
    rx_idle       = 57;
    fail_count    = 0;
    words_sent    = 0;
    queries_sent  = 0;
    words_seen    = 0;
    tb_timer      = 16'hffff;
    gray_idx      = 0;
    motion        = 1;
    odo_limit     = RESET_LIMIT;
    odo_prev_time = '0;
    odo_prev_hall = '0;
    odo_stopped   = 1'b0;
    odo_position  = '0;
    odo_ptr       = 0;
    foreach (odo_interval[i]) begin
      odo_interval[i] = '0;
      odo_dir[i] = 0;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      offer_word(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].timer, DIRECTED_ROWS[i].hall,
                 DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end
    s_axis_tvalid <= 1'b0;
    gray_idx = 0;

    write_limit(TIMER_W'($urandom_range(1, 65534)));
    stall_req = 1'b1;
    run_phase(140, 31, 57);
    write_limit('0);
    run_phase(130, 57, 31);
    write_limit('1);
    run_phase(130, 0, 0);

    while (pending_odometry.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d words (%0d speed queries), checked %0d output words.",
             words_sent, queries_sent, words_seen);
    $display("Limits: reset, random, zero and full scale; one long output stall.");
    if (fail_count == 0 && pending_odometry.size() == 0) begin
      $display("hall_quadrature_odometer_speed_core test passed");
    end else begin
      $display("hall_quadrature_odometer_speed_core test failed");
    end
    $finish;
  end

endmodule
